>>> design/three_level_queue_with_boost_assert.svh
// Assertion macros shared by the queue block.
`ifndef THREE_LEVEL_QUEUE_WITH_BOOST_ASSERT_SVH
`define THREE_LEVEL_QUEUE_WITH_BOOST_ASSERT_SVH
`ifndef SYNTH
`define TLQB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TLQB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TLQB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TLQB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> design/tlqb_pkg.sv
// Types, codes and constants of the three-level queue block.
package tlqb_pkg;

	typedef enum logic [1:0] {
		CMD_ENQ   = 2'd0,
		CMD_DEQ   = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_BOOST = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_BOOST
	} state_t;

	localparam int NUM_LVL = 3;

	// Internal level indices.
	localparam logic [1:0] LVL_1 = 2'd0;
	localparam logic [1:0] LVL_2 = 2'd1;
	localparam logic [1:0] LVL_3 = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic signed [31:0] EMPTY_WORD = -32'sd99;
	localparam int                 DROP_W     = 9;
	localparam logic [DROP_W-1:0]  DROP_MAX   = 9'd511;

	typedef struct packed {
		logic [1:0]         command;
		logic [1:0]         level;
		logic signed [31:0] data_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] data_out;
		logic [1:0]         status;
		logic               level_empty;
		logic [DROP_W-1:0]  dropped_count;
	} out_item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} lvl_flags_t;

	// Level field to internal index: 1 and 2 map directly, anything else is level 3.
	function automatic logic [1:0] pick_level(input logic [1:0] lv);
		logic [1:0] idx;
		case (lv)
			2'd1:    idx = LVL_1;
			2'd2:    idx = LVL_2;
			default: idx = LVL_3;
		endcase
		return idx;
	endfunction

endpackage

>>> design/tlqb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlqb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/tlqb_lvl.sv
// Head, tail and fill count of one circular level.
module tlqb_lvl #(
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic                     pop,
	output logic [$clog2(DEPTH)-1:0] head,
	output logic [$clog2(DEPTH)-1:0] tail,
	output tlqb_pkg::lvl_flags_t     flags
);

	import tlqb_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] head_inc;
	logic [IW-1:0] tail_inc;

	always_comb begin
		head_inc = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);
		tail_inc = (tail_q == IW'(DEPTH - 1)) ? '0 : tail_q + IW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_inc;
			end
			if (pop) begin
				head_q <= head_inc;
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign head        = head_q;
	assign tail        = tail_q;
	assign flags.empty = (count_q == '0);
	assign flags.full  = (count_q == CW'(DEPTH));

endmodule

>>> design/three_level_queue_with_boost.sv
// Top level: three-level queue with command sequencer and boost mover.
// Enqueue, query and dequeue of an empty level: the result is registered from the execute state.
// Dequeue of a stored word: the RAM read is registered, so the result comes from the read state after execute.
// Boost moves entries one per cycle from level 2 or 3 to level 1, or drops them; the result follows the drain.
// Start is refused until the result; the next item can be taken in the cycle the result is shown.
// Reset clears the heads, tails and fill counts of all levels; RAM contents stay. Results cannot be stalled.
`include "three_level_queue_with_boost_assert.svh"

module three_level_queue_with_boost #(
	parameter int DEPTH = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tlqb_pkg::in_item_t  req,
	output logic                busy,
	output logic                done,
	output tlqb_pkg::out_item_t rsp
);

	import tlqb_pkg::*;

	localparam int IW = $clog2(DEPTH);

	state_t          state_q, state_d;
	cmd_t            cmd_q;
	logic [1:0]      lvl_q;
	logic [31:0]     data_q;
	logic [DROP_W-1:0] drop_q, drop_d;
	logic            pend_s1, pend_d;
	logic [1:0]      src_s1, src_d;
	out_item_t       rsp_q, rsp_d;
	logic            done_q, done_d;
	logic            accept;

	logic            push [NUM_LVL];
	logic            pop  [NUM_LVL];
	logic            rd   [NUM_LVL];
	logic [IW-1:0]   head [NUM_LVL];
	logic [IW-1:0]   tail [NUM_LVL];
	lvl_flags_t      flags[NUM_LVL];
	logic [31:0]     rdata[NUM_LVL];
	logic [31:0]     wdata[NUM_LVL];

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	for (genvar i = 0; i < NUM_LVL; i++) begin : g_lvl
		// During boost, level 1 is fed from the word just read out of level 2 or 3.
		assign wdata[i] = (state_q == S_BOOST) ? rdata[src_s1] : data_q;

		tlqb_lvl #(
			.DEPTH(DEPTH)
		) u_lvl (
			.clk   (clk),
			.arst_n(arst_n),
			.push  (push[i]),
			.pop   (pop[i]),
			.head  (head[i]),
			.tail  (tail[i]),
			.flags (flags[i])
		);

		tlqb_ram #(
			.WIDTH(32),
			.DEPTH(DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (push[i]),
			.waddr(tail[i]),
			.wdata(wdata[i]),
			.re   (rd[i]),
			.raddr(head[i]),
			.rdata(rdata[i])
		);
	end

	always_comb begin
		state_d = state_q;
		drop_d  = drop_q;
		pend_d  = 1'b0;
		src_d   = src_s1;
		rsp_d   = rsp_q;
		done_d  = 1'b0;
		for (int i = 0; i < NUM_LVL; i++) begin
			push[i] = 1'b0;
			pop[i]  = 1'b0;
			rd[i]   = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (cmd_q)
					CMD_ENQ: begin
						push[lvl_q] = !flags[lvl_q].full;
						// A level is never empty right after an enqueue: full implies entries.
						rsp_d   = '{data_out: '0,
							status: flags[lvl_q].full ? ST_FULL : ST_OK,
							level_empty: 1'b0, dropped_count: '0};
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
					CMD_DEQ: begin
						if (flags[lvl_q].empty) begin
							rsp_d   = '{data_out: EMPTY_WORD, status: ST_EMPTY,
								level_empty: 1'b1, dropped_count: '0};
							done_d  = 1'b1;
							state_d = S_IDLE;
						end else begin
							rd[lvl_q]  = 1'b1;
							pop[lvl_q] = 1'b1;
							state_d    = S_READ;
						end
					end
					CMD_QUERY: begin
						rsp_d   = '{data_out: '0, status: ST_OK,
							level_empty: flags[lvl_q].empty, dropped_count: '0};
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
					CMD_BOOST: begin
						drop_d  = '0;
						state_d = S_BOOST;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_READ: begin
				rsp_d   = '{data_out: rdata[lvl_q], status: ST_OK,
					level_empty: flags[lvl_q].empty, dropped_count: '0};
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_BOOST: begin
				// Write stage: the word read in the previous cycle goes to level 1 or is lost.
				if (pend_s1) begin
					if (!flags[LVL_1].full) begin
						push[LVL_1] = 1'b1;
					end else if (drop_q != DROP_MAX) begin
						drop_d = drop_q + DROP_W'(1);
					end
				end
				// Read stage: level 2 is drained before level 3.
				if (!flags[LVL_2].empty) begin
					rd[LVL_2]  = 1'b1;
					pop[LVL_2] = 1'b1;
					pend_d     = 1'b1;
					src_d      = LVL_2;
				end else if (!flags[LVL_3].empty) begin
					rd[LVL_3]  = 1'b1;
					pop[LVL_3] = 1'b1;
					pend_d     = 1'b1;
					src_d      = LVL_3;
				end else if (!pend_s1) begin
					rsp_d   = '{data_out: '0,
						status: (drop_q != '0) ? ST_FULL : ST_OK,
						level_empty: flags[lvl_q].empty, dropped_count: drop_q};
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= pend_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(req.command);
			lvl_q  <= pick_level(req.level);
			data_q <= req.data_in;
		end
		drop_q <= drop_d;
		src_s1 <= src_d;
		rsp_q  <= rsp_d;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`TLQB_ASSERT_IMP(a_done_after_work, clk, arst_n, done_q, $past(state_q) != S_IDLE, "result strobe without work")
	`TLQB_ASSERT_NXT(a_busy_after_accept, clk, arst_n, accept, busy, "accepted item did not raise busy")
	`TLQB_ASSERT_IMP(a_no_write_when_full, clk, arst_n, push[LVL_1], !flags[LVL_1].full, "write into full level 1")
	`TLQB_ASSERT_IMP(a_empty_word, clk, arst_n, done_q && (rsp_q.status == ST_EMPTY), rsp_q.data_out == EMPTY_WORD, "empty dequeue without marker word")
	`TLQB_ASSERT_IMP(a_boost_drained, clk, arst_n, done_q && (cmd_q == CMD_BOOST), flags[LVL_2].empty && flags[LVL_3].empty, "boost left entries in levels 2 or 3")

endmodule

>>> tb/tb.sv
// Self-checking testbench for the three-level queue with boost.
`timescale 1ns / 1ps

module tb;
	import tlqb_pkg::*;

	localparam int DEPTH     = 128;
	localparam int HEAD_W    = $clog2(DEPTH);
	localparam int NUM_ITEMS = 900;
	localparam int LIMIT     = 400000;

	typedef struct {
		in_item_t item;
		bit       drain_first;
	} pending_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	in_item_t  req = '0;
	logic      busy;
	logic      done;
	out_item_t rsp;

	pending_t  pending[$];
	out_item_t expected_rsp[$];
	int        n_items = 0;
	int        n_accepted = 0;
	int        n_done = 0;
	int        mismatches = 0;
	int        cycles = 0;

	// Driver bookkeeping, touched by the driver only.
	int        burst_left = 1;
	int        gap_left = 0;
	logic      took;
	logic      go;

	// Result expected by the monitor for the item now being checked.
	out_item_t want;

	// Shadow copy of the three levels.
	logic [31:0]       lvl_mem [NUM_LVL][DEPTH];
	logic [HEAD_W-1:0] lvl_head [NUM_LVL] = '{default: '0};
	logic [HEAD_W:0]   lvl_count [NUM_LVL] = '{default: '0};

	int n_per_cmd [4] = '{default: 0};
	int n_full_hits = 0;
	int n_empty_hits = 0;
	int n_drop_boosts = 0;
	int most_dropped = 0;

	three_level_queue_with_boost #(.DEPTH(DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit level_push(logic [1:0] q, logic [31:0] word);
		int tail;
		if (lvl_count[q] >= DEPTH)
			return 1'b0;
		tail = (lvl_head[q] + lvl_count[q]) % DEPTH;
		lvl_mem[q][tail] = word;
		lvl_count[q] = lvl_count[q] + 1'b1;
		return 1'b1;
	endfunction

	function automatic logic [31:0] level_pop(logic [1:0] q);
		logic [31:0] word;
		word = lvl_mem[q][lvl_head[q]];
		lvl_head[q] = (lvl_head[q] == HEAD_W'(DEPTH - 1)) ? '0 : lvl_head[q] + 1'b1;
		lvl_count[q] = lvl_count[q] - 1'b1;
		return word;
	endfunction

	// Applies one command to the shadow levels and returns the response it should give.
	function automatic out_item_t run_queue_cmd(in_item_t it);
		out_item_t         res;
		logic [1:0]        q;
		logic [DROP_W-1:0] lost;
		logic [31:0]       word;
		res = '0;
		lost = '0;
		case (it.level)
			2'd1:    q = LVL_1;
			2'd2:    q = LVL_2;
			default: q = LVL_3;
		endcase
		n_per_cmd[it.command]++;
		case (cmd_t'(it.command))
			CMD_ENQ: begin
				if (!level_push(q, it.data_in)) begin
					res.status = ST_FULL;
					n_full_hits++;
				end
			end
			CMD_DEQ: begin
				if (lvl_count[q] == 0) begin
					res.data_out = EMPTY_WORD;
					res.status = ST_EMPTY;
					n_empty_hits++;
				end else begin
					res.data_out = level_pop(q);
				end
			end
			CMD_BOOST: begin
				// Level 2 drains first, then level 3, each in arrival order.
				for (int src = int'(LVL_2); src <= int'(LVL_3); src++) begin
					while (lvl_count[src] != 0) begin
						word = level_pop(src[1:0]);
						if (!level_push(LVL_1, word) && lost < DROP_MAX)
							lost = lost + 1'b1;
					end
				end
				if (lost != 0) begin
					res.status = ST_FULL;
					n_drop_boosts++;
					if (int'(lost) > most_dropped)
						most_dropped = int'(lost);
				end
			end
			default: ;
		endcase
		res.level_empty = (lvl_count[q] == 0);
		res.dropped_count = lost;
		return res;
	endfunction

	task automatic check_field(string fname, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", fname, exp_v, act_v);
			mismatches++;
		end
	endtask

	task automatic add_item(cmd_t c, logic [1:0] lv, logic [31:0] d, bit hold = 1'b0);
		pending_t p;
		p.item.command = c;
		p.item.level = lv;
		p.item.data_in = d;
		p.drain_first = hold;
		pending.push_back(p);
		n_items++;
	endtask

	// Driver: bursts of items separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			took = start && !busy;
			if (took)
				void'(pending.pop_front());
			if (start && !took) begin
				go = 1'b1;
			end else if (gap_left > 0) begin
				gap_left = gap_left - 1;
				go = 1'b0;
			end else if (pending.size() == 0) begin
				go = 1'b0;
			end else if (pending[0].drain_first && (took || n_done < n_accepted)) begin
				go = 1'b0;
			end else begin
				go = 1'b1;
				burst_left = burst_left - 1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
			start <= go;
			if (go)
				req <= pending[0].item;
		end
	end

	// Monitor: checks each result, then records the item accepted at this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_accepted <= 0;
			n_done <= 0;
		end else begin
			if (done) begin
				if (expected_rsp.size() == 0) begin
					$error("result with no item outstanding: data_out %0d status %0d",
						rsp.data_out, rsp.status);
					mismatches++;
				end else begin
					want = expected_rsp.pop_front();
					check_field("data_out", want.data_out, rsp.data_out);
					check_field("status", want.status, rsp.status);
					check_field("level_empty", want.level_empty, rsp.level_empty);
					check_field("dropped_count", want.dropped_count, rsp.dropped_count);
				end
				n_done <= n_done + 1;
			end
			if (start && !busy) begin
				expected_rsp.push_back(run_queue_cmd(req));
				n_accepted <= n_accepted + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int   r;
		int   k1;
		int   k2;
		int   k3;
		logic [1:0] lv;
		bit   first;
		first = 1'b1;

		// Directed: empty levels, extreme words, level 0 aliasing level 3, boosts.
		add_item(CMD_QUERY, 2'd1, 32'd0);
		add_item(CMD_DEQ, 2'd1, 32'hFFFF_FFFF);
		add_item(CMD_DEQ, 2'd0, 32'd0);
		add_item(CMD_BOOST, 2'd2, 32'd0);
		add_item(CMD_ENQ, 2'd1, 32'h7FFF_FFFF);
		add_item(CMD_ENQ, 2'd2, 32'h8000_0000);
		add_item(CMD_ENQ, 2'd0, 32'h0000_0000);
		add_item(CMD_ENQ, 2'd3, 32'hFFFF_FFFF);
		add_item(CMD_QUERY, 2'd0, 32'h5555_5555);
		add_item(CMD_QUERY, 2'd2, 32'hAAAA_AAAA);
		add_item(CMD_DEQ, 2'd3, 32'd0, 1'b1);
		add_item(CMD_ENQ, 2'd2, EMPTY_WORD);
		add_item(CMD_ENQ, 2'd3, 32'h0000_0001);
		add_item(CMD_BOOST, 2'd1, 32'd0);
		add_item(CMD_QUERY, 2'd3, 32'd0);
		add_item(CMD_DEQ, 2'd1, 32'd0);
		add_item(CMD_DEQ, 2'd1, 32'd0);
		add_item(CMD_DEQ, 2'd1, 32'd0);
		add_item(CMD_DEQ, 2'd1, 32'd0);
		add_item(CMD_DEQ, 2'd2, 32'd0);
		add_item(CMD_BOOST, 2'd0, 32'd0);

		// Random: mixed traffic, fills past full, long drains and overflowing boosts.
		while (n_items < NUM_ITEMS) begin
			r = first ? 17 : $urandom_range(0, 19);
			first = 1'b0;
			if (r <= 11 || r >= 18) begin
				k1 = $urandom_range(10, 40);
				for (int i = 0; i < k1; i++) begin
					k2 = $urandom_range(0, 99);
					add_item(k2 < 40 ? CMD_ENQ : k2 < 70 ? CMD_DEQ : k2 < 85 ? CMD_QUERY : CMD_BOOST,
						2'($urandom_range(0, 3)), $urandom(), r >= 18 && i == 0);
				end
			end else if (r <= 14) begin
				lv = 2'($urandom_range(0, 3));
				k1 = $urandom_range(20, DEPTH + 7);
				for (int i = 0; i < k1; i++)
					add_item(CMD_ENQ, lv, $urandom());
			end else if (r <= 16) begin
				lv = 2'($urandom_range(0, 3));
				k1 = $urandom_range(20, DEPTH + 7);
				for (int i = 0; i < k1; i++)
					add_item(CMD_DEQ, lv, $urandom());
			end else begin
				// Load level 1 with many entries, then boost into it, which may be more than it can take.
				k1 = $urandom_range(60, DEPTH);
				k2 = $urandom_range(0, 60);
				k3 = $urandom_range(0, 60);
				for (int i = 0; i < k1; i++)
					add_item(CMD_ENQ, 2'd1, $urandom());
				for (int i = 0; i < k2; i++)
					add_item(CMD_ENQ, 2'd2, $urandom());
				for (int i = 0; i < k3; i++)
					add_item(CMD_ENQ, $urandom_range(0, 1) ? 2'd3 : 2'd0, $urandom());
				add_item(CMD_BOOST, 2'($urandom_range(0, 3)), $urandom());
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending.size() != 0 || start || expected_rsp.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("Ran %0d items: %0d enqueue, %0d dequeue, %0d query, %0d boost.",
			n_accepted, n_per_cmd[CMD_ENQ], n_per_cmd[CMD_DEQ], n_per_cmd[CMD_QUERY],
			n_per_cmd[CMD_BOOST]);
		$display("Full enqueues %0d, empty dequeues %0d, lossy boosts %0d (most lost %0d).",
			n_full_hits, n_empty_hits, n_drop_boosts, most_dropped);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
